// File: rtl/rsbs_pkg.sv
// shared types and constants for the sync button sender
// frame codes, frame lengths, action codes, register indexes and the config bundle
// no dependencies
package rsbs_pkg;

    localparam int CODE_W = 11;
    localparam int LEN_W  = 4;
    localparam int HOLD_W = 12;
    localparam int STEP_W = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int PUSH_MAX = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 12'd4095;

    // frame codes, bit i goes out i-th
    localparam logic [CODE_W-1:0] FR_RED1      = 11'h074;
    localparam logic [CODE_W-1:0] FR_RED2      = 11'h0F4;
    localparam logic [CODE_W-1:0] FR_RED3      = 11'h2F4;
    localparam logic [CODE_W-1:0] FR_RED4      = 11'h3F4;
    localparam logic [CODE_W-1:0] FR_OFF       = 11'h034;
    localparam logic [CODE_W-1:0] FR_SYNC_SLIM = 11'h480;
    localparam logic [CODE_W-1:0] FR_SYNC_FAT  = 11'h080;
    localparam logic [CODE_W-1:0] FR_POWER_OFF = 11'h240;

    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd10;
    localparam logic [LEN_W-1:0] LEN_LONG  = 4'd11;

    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_SYNC      = 2'd1;
    localparam logic [1:0] ACT_POWER_OFF = 2'd2;

    localparam logic [2:0] LED_NONE  = 3'd0;
    localparam logic [2:0] LED_ONE   = 3'd1;
    localparam logic [2:0] LED_TWO   = 3'd2;
    localparam logic [2:0] LED_THREE = 3'd3;
    localparam logic [2:0] LED_FOUR  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_OFF   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLIM_MODEL  = 3'd5;

    typedef struct packed {
        logic [STEP_W-1:0] tick_step_ms;
        logic [HOLD_W-1:0] level_one_ms;
        logic [HOLD_W-1:0] level_two_ms;
        logic [HOLD_W-1:0] level_three_ms;
        logic [HOLD_W-1:0] power_off_ms;
        logic              slim_model;
    } cfg_t;

    // up to three frames queued by one request, in order
    typedef struct packed {
        logic [1:0]                          num;
        logic [PUSH_MAX-1:0][CODE_W-1:0]     codes;
        logic [PUSH_MAX-1:0][LEN_W-1:0]      lens;
    } push_req_t;

endpackage

// File: rtl/rsbs_front.sv
// front end: wake, hold time tracking and frame selection per request
// depends on rsbs_pkg
module rsbs_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   tick,
    input  logic                   button_level,
    input  rsbs_pkg::cfg_t         cfg,
    output rsbs_pkg::push_req_t    push,
    output logic [1:0]             action,
    output logic [2:0]             led_level
);

    logic                          awake_reg, awake_next;
    logic                          pending_reg, pending_next;
    logic [rsbs_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [2:0]                    led_reg, led_next;
    logic                          awake_now;
    logic                          po_hit;
    logic [rsbs_pkg::HOLD_W-1:0]   hold_capped;
    logic [rsbs_pkg::HOLD_W:0]     hold_sum;
    logic [rsbs_pkg::CODE_W-1:0]   first_code;
    logic [2:0]                    first_led;

    always_comb
    begin
        awake_now   = awake_reg | ~button_level;
        po_hit      = hold_reg >= cfg.power_off_ms;
        hold_capped = po_hit ? cfg.power_off_ms : hold_reg;
        hold_sum    = {1'b0, hold_capped} + (rsbs_pkg::HOLD_W + 1)'(cfg.tick_step_ms);

        // thresholds tested top down, first met wins
        if (po_hit)
        begin
            first_code = rsbs_pkg::FR_RED4;
            first_led  = rsbs_pkg::LED_FOUR;
        end
        else if (hold_reg >= cfg.level_three_ms)
        begin
            first_code = rsbs_pkg::FR_RED3;
            first_led  = rsbs_pkg::LED_THREE;
        end
        else if (hold_reg >= cfg.level_two_ms)
        begin
            first_code = rsbs_pkg::FR_RED2;
            first_led  = rsbs_pkg::LED_TWO;
        end
        else if (hold_reg >= cfg.level_one_ms)
        begin
            first_code = rsbs_pkg::FR_RED1;
            first_led  = rsbs_pkg::LED_ONE;
        end
        else
        begin
            first_code = rsbs_pkg::FR_OFF;
            first_led  = rsbs_pkg::LED_NONE;
        end

        awake_next   = awake_now;
        pending_next = pending_reg;
        hold_next    = hold_reg;
        led_next     = led_reg;
        action       = rsbs_pkg::ACT_NONE;
        push.num     = 2'd0;
        push.codes   = '0;
        push.lens    = '0;

        if (awake_now && tick)
        begin
            push.codes[0] = first_code;
            push.lens[0]  = rsbs_pkg::LEN_SHORT;
            if (button_level)
            begin
                // release: current level frame, led off, then sync or power-off
                push.num      = 2'd3;
                push.codes[1] = rsbs_pkg::FR_OFF;
                push.lens[1]  = rsbs_pkg::LEN_SHORT;
                if (pending_reg || po_hit)
                begin
                    push.codes[2] = rsbs_pkg::FR_POWER_OFF;
                    push.lens[2]  = rsbs_pkg::LEN_SHORT;
                    action        = rsbs_pkg::ACT_POWER_OFF;
                end
                else if (cfg.slim_model)
                begin
                    push.codes[2] = rsbs_pkg::FR_SYNC_SLIM;
                    push.lens[2]  = rsbs_pkg::LEN_LONG;
                    action        = rsbs_pkg::ACT_SYNC;
                end
                else
                begin
                    push.codes[2] = rsbs_pkg::FR_SYNC_FAT;
                    push.lens[2]  = rsbs_pkg::LEN_SHORT;
                    action        = rsbs_pkg::ACT_SYNC;
                end
                pending_next = 1'b0;
                hold_next    = '0;
                awake_next   = 1'b0;
                led_next     = rsbs_pkg::LED_NONE;
            end
            else
            begin
                push.num     = 2'd1;
                pending_next = pending_reg | po_hit;
                hold_next    = hold_sum[rsbs_pkg::HOLD_W] ? rsbs_pkg::HOLD_MAX
                                                          : hold_sum[rsbs_pkg::HOLD_W-1:0];
                led_next     = first_led;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awake_reg   <= 1'b0;
            pending_reg <= 1'b0;
            hold_reg    <= '0;
            led_reg     <= rsbs_pkg::LED_NONE;
        end
        else if (step)
        begin
            awake_reg   <= awake_next;
            pending_reg <= pending_next;
            hold_reg    <= hold_next;
            led_reg     <= led_next;
        end
    end

    assign led_level = led_reg;

endmodule

// File: rtl/rsbs_queue.sv
// frame queue between front end and sender, head always in entry zero
// depends on rsbs_pkg
module rsbs_queue
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int FRAME_BITS  = 11
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  rsbs_pkg::push_req_t        push,
    input  logic                       pop,
    output logic [FRAME_BITS-1:0]      head_bits,
    output logic [rsbs_pkg::LEN_W-1:0] head_len,
    output logic                       filled
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [FRAME_BITS-1:0]      bits_reg [QUEUE_DEPTH];
    logic [rsbs_pkg::LEN_W-1:0] len_reg  [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0]      bits_mid [QUEUE_DEPTH];
    logic [rsbs_pkg::LEN_W-1:0] len_mid  [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0]      bits_next [QUEUE_DEPTH];
    logic [rsbs_pkg::LEN_W-1:0] len_next  [QUEUE_DEPTH];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           count_mid;

    always_comb
    begin
        bits_mid  = bits_reg;
        len_mid   = len_reg;
        count_mid = count_reg;
        // frames beyond a full queue are dropped
        for (int k = 0; k < rsbs_pkg::PUSH_MAX; k++)
        begin
            if ((k < int'(push.num)) && (count_mid < CNT_W'(QUEUE_DEPTH)))
            begin
                bits_mid[count_mid[PTR_W-1:0]] = FRAME_BITS'(push.codes[k]);
                len_mid[count_mid[PTR_W-1:0]]  = push.lens[k];
                count_mid = count_mid + 1'b1;
            end
        end

        bits_next  = bits_mid;
        len_next   = len_mid;
        count_next = count_mid;
        if (pop && (count_mid != '0))
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                bits_next[i] = bits_mid[i + 1];
                len_next[i]  = len_mid[i + 1];
            end
            count_next = count_mid - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            bits_reg <= bits_next;
            len_reg  <= len_next;
        end
    end

    assign head_bits = bits_reg[0];
    assign head_len  = len_reg[0];
    assign filled    = count_mid != '0;

endmodule

// File: rtl/rsbs_sender.sv
// serial sender: shifts the head frame out on the module clock edges
// depends on rsbs_pkg
module rsbs_sender
#(
    parameter int FRAME_BITS = 11
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       module_clock,
    input  logic [FRAME_BITS-1:0]      head_bits,
    input  logic [rsbs_pkg::LEN_W-1:0] head_len,
    input  logic                       filled,
    output logic                       pop,
    output logic                       data_enable,
    output logic                       data_level
);

    localparam int IDX_W = $clog2(FRAME_BITS + 1);
    localparam int SEL_W = $clog2(FRAME_BITS);

    logic             sending_reg, sending_next;
    logic             phase_reg, phase_next;
    logic             prev_reg, prev_next;
    logic             en_reg, en_next;
    logic             lvl_reg, lvl_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] idx_inc;

    always_comb
    begin
        sending_next = sending_reg;
        phase_next   = phase_reg;
        prev_next    = module_clock;
        en_next      = en_reg;
        lvl_next     = lvl_reg;
        idx_next     = idx_reg;
        idx_inc      = idx_reg + 1'b1;
        pop          = 1'b0;

        if (sending_reg)
        begin
            if (!phase_reg && prev_reg && !module_clock)
            begin
                // falling edge drives the bit
                lvl_next   = head_bits[idx_reg[SEL_W-1:0]];
                phase_next = 1'b1;
            end
            else if (phase_reg && !prev_reg && module_clock)
            begin
                phase_next = 1'b0;
                if ((idx_inc >= IDX_W'(head_len)) || (idx_inc >= IDX_W'(FRAME_BITS)))
                begin
                    // last bit done, line driven high and the frame popped
                    lvl_next     = 1'b1;
                    sending_next = 1'b0;
                    idx_next     = '0;
                    pop          = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            en_next = 1'b1;
        end
        else if (filled)
        begin
            sending_next = 1'b1;
            idx_next     = '0;
            phase_next   = 1'b0;
            en_next      = 1'b1;
            lvl_next     = 1'b0;
            prev_next    = 1'b1;
        end
        else
        begin
            en_next  = 1'b0;
            lvl_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            phase_reg   <= 1'b0;
            prev_reg    <= 1'b1;
            en_reg      <= 1'b0;
            lvl_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else if (step)
        begin
            sending_reg <= sending_next;
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            en_reg      <= en_next;
            lvl_reg     <= lvl_next;
            idx_reg     <= idx_next;
        end
    end

    assign data_enable = en_reg;
    assign data_level  = lvl_reg;

endmodule

// File: rtl/rf_module_sync_button_sender.sv
// top level of the sync button sender: config registers, output handshake
// depends on rsbs_pkg, rsbs_front, rsbs_queue, rsbs_sender
//
// One request per clock cycle while in_ready is high: each request carries one
// sample of the tick, the sync button and the module clock line, and yields one
// result with the data line enable and level, the action queued and the red
// quadrants lit. Every request passes through the front end (wake, hold time,
// frame choice), the frame queue and the sender, all of which update together
// when the request is taken; the result then sits in the output stage until it
// is taken. in_ready is high whenever the output stage is empty or being emptied,
// so a stall on the output side holds the input for exactly as long. The queue
// holds QUEUE_DEPTH frames of FRAME_BITS bits; frames that find it full are
// dropped, while action and led_level still report them. Configuration writes
// land at once and are meant for idle periods only.
module rf_module_sync_button_sender
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int FRAME_BITS  = 11
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                tick,
    input  logic                                button_level,
    input  logic                                module_clock,
    // result side
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                data_enable,
    output logic                                data_level,
    output logic [1:0]                          action,
    output logic [2:0]                          led_level,
    // configuration
    input  logic                                cfg_we,
    input  logic [rsbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rsbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rsbs_pkg::cfg_t             cfg_reg;
    rsbs_pkg::push_req_t        push;
    logic                       step;
    logic                       out_valid_reg;
    logic [1:0]                 action_reg;
    logic [1:0]                 action_now;
    logic                       pop;
    logic                       filled;
    logic [FRAME_BITS-1:0]      head_bits;
    logic [rsbs_pkg::LEN_W-1:0] head_len;

    // a request is taken whenever the output stage can take its result
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // register file, writes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step_ms   <= 10'd200;
            cfg_reg.level_one_ms   <= 12'd250;
            cfg_reg.level_two_ms   <= 12'd500;
            cfg_reg.level_three_ms <= 12'd750;
            cfg_reg.power_off_ms   <= 12'd1000;
            cfg_reg.slim_model     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsbs_pkg::REG_TICK_STEP:
                    cfg_reg.tick_step_ms <= cfg_data[rsbs_pkg::STEP_W-1:0];
                rsbs_pkg::REG_LEVEL_ONE:   cfg_reg.level_one_ms   <= cfg_data;
                rsbs_pkg::REG_LEVEL_TWO:   cfg_reg.level_two_ms   <= cfg_data;
                rsbs_pkg::REG_LEVEL_THREE: cfg_reg.level_three_ms <= cfg_data;
                rsbs_pkg::REG_POWER_OFF:   cfg_reg.power_off_ms   <= cfg_data;
                rsbs_pkg::REG_SLIM_MODEL:  cfg_reg.slim_model     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // front end: decides which frames a request queues
    rsbs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .tick         (tick),
        .button_level (button_level),
        .cfg          (cfg_reg),
        .push         (push),
        .action       (action_now),
        .led_level    (led_level)
    );

    // queue between the two sides
    rsbs_queue
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .push      (push),
        .pop       (pop),
        .head_bits (head_bits),
        .head_len  (head_len),
        .filled    (filled)
    );

    // back end: shifts the head frame out on the module clock
    rsbs_sender
    #(
        .FRAME_BITS (FRAME_BITS)
    )
    u_sender
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .module_clock (module_clock),
        .head_bits    (head_bits),
        .head_len     (head_len),
        .filled       (filled),
        .pop          (pop),
        .data_enable  (data_enable),
        .data_level   (data_level)
    );

    // output stage; the line and led registers in the sub-blocks only move on a
    // taken request, so they hold with the result while it waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            action_reg    <= rsbs_pkg::ACT_NONE;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                action_reg    <= action_now;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

endmodule
